// ===== hw/rtl/caf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caf_pkg: shared types and constants of the complementary attitude filter
// Holds the sequencer state and operation codes, register indexes, angle
// limits and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package caf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 24;  // arctangent table depth
   localparam int ITER_W           = 5;   // covers the table index and the root steps
   localparam int SQRT_STEPS       = 30;  // root digits of (ay^2 + az^2) * 2^28

   // register indexes of the configuration port
   localparam logic REG_BLEND_WEIGHT  = 1'b0;
   localparam logic REG_SAMPLE_PERIOD = 1'b1;

   localparam logic [16:0] WEIGHT_RST = 17'd64225;
   localparam logic [15:0] PERIOD_RST = 16'd655;
   localparam logic [16:0] ONE_Q16    = 17'd65536;

   localparam logic signed [25:0] DEG90   = 26'sd5898240;
   localparam logic signed [30:0] DEG180  = 31'sd11796480;
   localparam logic signed [30:0] DEG360  = 31'sd23592960;
   localparam logic signed [31:0] ANG_MAX = 32'sd16777215;
   localparam logic signed [31:0] ANG_MIN = -32'sd16777216;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_SQRT,
      ST_CINIT,
      ST_CITER,
      ST_POST,
      ST_YAW,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_SQ_Y,
      OP_SQ_Z,
      OP_INC_X,
      OP_INC_Y,
      OP_INC_Z,
      OP_ROLL_G,
      OP_ROLL_A,
      OP_ROLL_W,
      OP_PITCH_G,
      OP_PITCH_A,
      OP_PITCH_W,
      OP_YAW_ADD
   } op_type;

   // atan(2^-i) in degrees, Q.16, rounded
   function automatic logic [21:0] atan_lut(input logic [ITER_W-1:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/complementary_attitude_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_attitude_filter: roll, pitch and yaw from one IMU sample
// A sample beat runs 5 shared-multiplier steps (squares, rate increments),
// the bit-serial root (30 digits), two CORDIC passes through one shift-add
// unit (a zero tilt vector skips its pass), 7 blend and yaw steps and the
// yaw wrap; a clear beat just zeroes the angles. One beat in flight: a new
// beat is taken only after the last result has entered the output register.
// Reset (synchronous, high) zeroes the angles and restores weight and period.
// ----------------------------------------------------------------------------
// Roll  = w*(roll  + gx*dt) + (1-w)*atan2(ay, az)
// Pitch = w*(pitch + gy*dt) + (1-w)*atan2(-ax, sqrt(ay^2+az^2))
// Yaw   = yaw + gz*dt, wrapped into [-180, 180) degrees
// All angles are signed Q8.16 degrees.
module complementary_attitude_filter
   import caf_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF  // 8 .. 24
) (
   input  logic         clock,
   input  logic         reset,
   // sample channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic [0:0]   req_tuser,   // mode (1 = clear all angles)
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,   // roll_out, pitch_out, yaw_out, zero pad
   // configuration port
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [16:0]  csr_wdata
);

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic pass_ff, pass_in;            // 0 = roll tilt, 1 = pitch tilt

   logic [16:0] weight_ff, weight_in;
   logic [15:0] period_ff, period_in;

   logic signed [24:0] roll_ff, roll_in;
   logic signed [24:0] pitch_ff, pitch_in;
   logic signed [24:0] yaw_ff, yaw_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [74:0] rsp_data_ff, rsp_data_in;

   // sample operands, held for the whole beat
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic signed [15:0] ax_in, ay_in, az_in, gx_in, gy_in, gz_in;

   logic [31:0] sq_ff, sq_in;           // ay^2 + az^2
   logic signed [28:0] ix_ff, iy_ff, iz_ff, ix_in, iy_in, iz_in;

   // bit-serial square root
   logic [59:0] src_ff, src_in;
   logic [31:0] rem_ff, rem_in;
   logic [29:0] root_ff, root_in;

   // CORDIC vector and angle
   logic signed [32:0] x_ff, y_ff, x_in, y_in;
   logic signed [25:0] z_ff, z_in;
   logic signed [25:0] troll_ff, tpitch_ff, troll_in, tpitch_in;

   logic signed [47:0] acc_ff, acc_in;
   logic signed [30:0] yacc_ff, yacc_in;

   // -------------------------------------------------------------------------
   // Shared datapath pieces
   // -------------------------------------------------------------------------
   logic [16:0] w_eff, w_cmp;
   logic signed [17:0] mul_a;
   logic signed [29:0] mul_b;
   logic signed [47:0] prod;
   logic signed [47:0] inc_full;
   logic signed [47:0] rnd_sum;
   logic signed [31:0] blend_q;
   logic signed [24:0] blend_sat;
   logic signed [29:0] roll_sum, pitch_sum;

   logic [33:0] rem_sh;
   logic [33:0] trial;

   logic signed [32:0] dx, dy;
   logic signed [25:0] atan_step;
   logic signed [32:0] cx, cy;

   logic in_beat;

   assign in_beat = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

   // weights above 1.0 act as 1.0
   assign w_eff = (weight_ff > ONE_Q16) ? ONE_Q16 : weight_ff;
   assign w_cmp = ONE_Q16 - w_eff;

   assign roll_sum  = 30'(roll_ff) + 30'(ix_ff);
   assign pitch_sum = 30'(pitch_ff) + 30'(iy_ff);

   // operand select of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_SQ_Y: begin
            mul_a = 18'(ay_ff);
            mul_b = 30'(ay_ff);
         end
         OP_SQ_Z: begin
            mul_a = 18'(az_ff);
            mul_b = 30'(az_ff);
         end
         OP_INC_X: begin
            mul_a = $signed({2'b0, period_ff});
            mul_b = 30'(gx_ff);
         end
         OP_INC_Y: begin
            mul_a = $signed({2'b0, period_ff});
            mul_b = 30'(gy_ff);
         end
         OP_INC_Z: begin
            mul_a = $signed({2'b0, period_ff});
            mul_b = 30'(gz_ff);
         end
         OP_ROLL_G: begin
            mul_a = $signed({1'b0, w_eff});
            mul_b = roll_sum;
         end
         OP_ROLL_A: begin
            mul_a = $signed({1'b0, w_cmp});
            mul_b = 30'(troll_ff);
         end
         OP_PITCH_G: begin
            mul_a = $signed({1'b0, w_eff});
            mul_b = pitch_sum;
         end
         OP_PITCH_A: begin
            mul_a = $signed({1'b0, w_cmp});
            mul_b = 30'(tpitch_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod     = mul_a * mul_b;
   // rate increment: floor((g*dt + 8) / 16)
   assign inc_full = prod + 48'sd8;
   // blend: floor((acc + 32768) / 65536), then saturate
   assign rnd_sum  = acc_ff + 48'sd32768;
   assign blend_q  = rnd_sum[47:16];
   assign blend_sat = (blend_q > ANG_MAX) ? ANG_MAX[24:0] :
                      (blend_q < ANG_MIN) ? ANG_MIN[24:0] : blend_q[24:0];

   // one restoring root digit per cycle
   assign rem_sh = {rem_ff, src_ff[59:58]};
   assign trial  = {2'b0, root_ff, 2'b01};

   // CORDIC micro-rotation, floor shifts
   assign dx        = y_ff >>> iter_ff;
   assign dy        = x_ff >>> iter_ff;
   assign atan_step = $signed({4'b0, atan_lut(iter_ff)});

   // start vector of each pass, operands scaled by 2^14
   always_comb begin
      if (!pass_ff) begin
         cx = $signed({{3{az_ff[15]}}, az_ff, 14'b0});
         cy = $signed({{3{ay_ff[15]}}, ay_ff, 14'b0});
      end else begin
         cx = $signed({3'b0, root_ff});
         cy = -$signed({{3{ax_ff[15]}}, ax_ff, 14'b0});
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer: next state and datapath updates
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      iter_in      = iter_ff;
      pass_in      = pass_ff;
      weight_in    = weight_ff;
      period_in    = period_ff;
      roll_in      = roll_ff;
      pitch_in     = pitch_ff;
      yaw_in       = yaw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gz_in        = gz_ff;
      sq_in        = sq_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      iz_in        = iz_ff;
      src_in       = src_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      troll_in     = troll_ff;
      tpitch_in    = tpitch_ff;
      acc_in       = acc_ff;
      yacc_in      = yacc_ff;

      // apply csr writes at once; the host must issue them while idle, unchecked here
      if (csr_wr_en) begin
         case (csr_index)
            REG_BLEND_WEIGHT:  weight_in = csr_wdata;
            REG_SAMPLE_PERIOD: period_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               ax_in = $signed(req_tdata[15:0]);
               ay_in = $signed(req_tdata[31:16]);
               az_in = $signed(req_tdata[47:32]);
               gx_in = $signed(req_tdata[63:48]);
               gy_in = $signed(req_tdata[79:64]);
               gz_in = $signed(req_tdata[95:80]);
               if (req_tuser[0]) begin
                  // clear command: drop the sample, zero the angles
                  roll_in  = '0;
                  pitch_in = '0;
                  yaw_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  op_in    = OP_SQ_Y;
                  state_in = ST_PRE;
               end
            end
         end

         // squares and rate increments
         ST_PRE: begin
            op_in = op_type'(4'(op_ff) + 4'd1);
            case (op_ff)
               OP_SQ_Y:  sq_in = prod[31:0];
               OP_SQ_Z:  sq_in = sq_ff + prod[31:0];
               OP_INC_X: ix_in = inc_full[32:4];
               OP_INC_Y: iy_in = inc_full[32:4];
               default: begin
                  iz_in    = inc_full[32:4];
                  src_in   = {sq_ff, 28'b0};
                  rem_in   = '0;
                  root_in  = '0;
                  iter_in  = '0;
                  state_in = ST_SQRT;
               end
            endcase
         end

         // magnitude of (ay, az), scaled by 2^14
         ST_SQRT: begin
            src_in = {src_ff[57:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = 32'(rem_sh - trial);
               root_in = {root_ff[28:0], 1'b1};
            end else begin
               rem_in  = rem_sh[31:0];
               root_in = {root_ff[28:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(SQRT_STEPS - 1)) begin
               pass_in  = 1'b0;
               state_in = ST_CINIT;
            end
         end

         // load the vector, fold the left half plane by +/-90 degrees
         ST_CINIT: begin
            iter_in = '0;
            if (cx == 33'sd0 && cy == 33'sd0) begin
               // atan2(0, 0) is zero
               if (!pass_ff) begin
                  troll_in = '0;
                  pass_in  = 1'b1;
                  state_in = ST_CINIT;
               end else begin
                  tpitch_in = '0;
                  op_in     = OP_ROLL_G;
                  state_in  = ST_POST;
               end
            end else begin
               if (cx < 33'sd0) begin
                  if (cy >= 33'sd0) begin
                     x_in = cy;
                     y_in = -cx;
                     z_in = DEG90;
                  end else begin
                     x_in = -cy;
                     y_in = cx;
                     z_in = -DEG90;
                  end
               end else begin
                  x_in = cx;
                  y_in = cy;
                  z_in = '0;
               end
               state_in = ST_CITER;
            end
         end

         ST_CITER: begin
            if (y_ff > 33'sd0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_step;
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_step;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               if (!pass_ff) begin
                  troll_in = z_in;
                  pass_in  = 1'b1;
                  state_in = ST_CINIT;
               end else begin
                  tpitch_in = z_in;
                  op_in     = OP_ROLL_G;
                  state_in  = ST_POST;
               end
            end
         end

         // blends and yaw increment
         ST_POST: begin
            op_in = op_type'(4'(op_ff) + 4'd1);
            case (op_ff)
               OP_ROLL_G:  acc_in   = prod;
               OP_ROLL_A:  acc_in   = acc_ff + prod;
               OP_ROLL_W:  roll_in  = blend_sat;
               OP_PITCH_G: acc_in   = prod;
               OP_PITCH_A: acc_in   = acc_ff + prod;
               OP_PITCH_W: pitch_in = blend_sat;
               default: begin
                  yacc_in  = 31'(yaw_ff) + 31'(iz_ff);
                  state_in = ST_YAW;
               end
            endcase
         end

         // wrap yaw one turn per cycle
         ST_YAW: begin
            if (yacc_ff >= DEG180) begin
               yacc_in = yacc_ff - DEG360;
            end else if (yacc_ff < -DEG180) begin
               yacc_in = yacc_ff + DEG360;
            end else begin
               yaw_in   = yacc_ff[24:0];
               state_in = ST_DONE;
            end
         end

         // hold until the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {yaw_ff, pitch_ff, roll_ff};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------------
   // Control and state registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SQ_Y;
         iter_ff      <= '0;
         pass_ff      <= 1'b0;
         weight_ff    <= WEIGHT_RST;
         period_ff    <= PERIOD_RST;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         iter_ff      <= iter_in;
         pass_ff      <= pass_in;
         weight_ff    <= weight_in;
         period_ff    <= period_in;
         roll_ff      <= roll_in;
         pitch_ff     <= pitch_in;
         yaw_ff       <= yaw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gz_ff       <= gz_in;
      sq_ff       <= sq_in;
      ix_ff       <= ix_in;
      iy_ff       <= iy_in;
      iz_ff       <= iz_in;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      troll_ff    <= troll_in;
      tpitch_ff   <= tpitch_in;
      acc_ff      <= acc_in;
      yacc_ff     <= yacc_in;
   end

endmodule

// ===== tb/complementary_attitude_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complementary_attitude_filter_tb: self-checking bench of the attitude filter
// Streams IMU sample and clear beats into the filter and scores every result
// beat against a typed value or an in-bench attitude predictor (CORDIC tilt,
// blend, yaw wrap). A directed table comes first, then randomized phases with
// fresh weight and period settings; in idling phases both channels pause in bursts.
// ----------------------------------------------------------------------------
module complementary_attitude_filter_tb
   import caf_pkg::*;
;

   localparam int     CORDIC_ITERS   = 16;
   localparam int     CYCLE_LIMIT    = 1_000_000;
   localparam int     SETTLE_CYCLES  = 100;    // beyond the worst sample latency
   localparam int     PHASE_BEATS    = 160;
   localparam int     PHASE_COUNT    = 8;
   localparam longint UNITY_Q16      = 65536;
   localparam longint QUARTER_TURN   = 5898240;
   localparam longint HALF_TURN      = 11796480;
   localparam longint FULL_TURN      = 23592960;
   localparam longint ANGLE_HI       = 16777215;
   localparam longint ANGLE_LO       = -16777216;
   localparam int     DIR_ROWS       = 26;

   typedef enum logic [1:0] {
      ROW_SAMPLE,
      ROW_CLEAR,
      ROW_CONFIG
   } row_kind_type;

   // sample/clear rows: f0..f5 = ax, ay, az, gx, gy, gz
   // config rows:       f0 = blend weight, f1 = sample period
   typedef struct {
      row_kind_type kind;
      int           f0, f1, f2, f3, f4, f5;
      bit           typed;
      int           er, ep, ey;
   } stim_row_type;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] ax, ay, az, gx, gy, gz;
   } imu_sample_type;

   typedef struct packed {
      logic signed [24:0] roll, pitch, yaw;
   } angles_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   logic [0:0]   req_tuser;   // mode
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;   // roll_out, pitch_out, yaw_out, zero pad
   logic         csr_wr_en;
   logic         csr_index;
   logic [16:0]  csr_wdata;

   // predictor state and its copy of the registers
   longint  att_roll, att_pitch, att_yaw;
   longint  cfg_weight, cfg_period;
   longint  atan_deg [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   angles_type     pending_angles [$];
   angles_type     head_angles;
   angles_type     seen_angles;
   stim_row_type   dir_rows [DIR_ROWS];
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   bit             idle_on        = 1'b1;
   int             stall_left     = 0;

   complementary_attitude_filter #(
      .CORDIC_STEPS(CORDIC_ITERS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // atan2(y, x) in Q.16 degrees; operands already scaled by 2^14
   function automatic longint tilt_deg(input longint y_in, input longint x_in);
      longint y, x, z, t, dx, dy;
      y = y_in;
      x = x_in;
      z = 0;
      if (x == 0 && y == 0)
         return 0;
      // fold the left half plane into the right one first
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_deg[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_deg[i];
         end
      end
      return z;
   endfunction

   function automatic longint root_u64(input logic [63:0] v_in);
      logic [63:0] v, res, b;
      v   = v_in;
      res = 0;
      b   = 64'h4000_0000_0000_0000;
      while (b > v)
         b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v   = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint mix_angle(input longint ang, input longint inc,
                                        input longint tilt, input longint w);
      longint acc;
      acc = (w * (ang + inc) + (UNITY_Q16 - w) * tilt + 32768) >>> 16;
      if (acc > ANGLE_HI)
         return ANGLE_HI;
      if (acc < ANGLE_LO)
         return ANGLE_LO;
      return acc;
   endfunction

   // advance the predictor by one beat and return the angles it reports
   function automatic angles_type update_attitude(input imu_sample_type s);
      longint     w, dt, ix, iy, iz, roll_tilt, pitch_tilt, mag, y;
      angles_type r;
      if (s.mode) begin
         att_roll  = 0;
         att_pitch = 0;
         att_yaw   = 0;
      end else begin
         w = cfg_weight;
         if (w > UNITY_Q16)
            w = UNITY_Q16;
         dt = cfg_period;
         ix = (longint'(s.gx) * dt + 8) >>> 4;
         iy = (longint'(s.gy) * dt + 8) >>> 4;
         iz = (longint'(s.gz) * dt + 8) >>> 4;
         roll_tilt  = tilt_deg(longint'(s.ay) * 16384, longint'(s.az) * 16384);
         mag        = root_u64(64'(longint'(s.ay) * s.ay + longint'(s.az) * s.az) << 28);
         pitch_tilt = tilt_deg(-longint'(s.ax) * 16384, mag);
         att_roll   = mix_angle(att_roll, ix, roll_tilt, w);
         att_pitch  = mix_angle(att_pitch, iy, pitch_tilt, w);
         // wrap yaw into [-180, 180) degrees
         y = (att_yaw + iz + HALF_TURN) % FULL_TURN;
         if (y < 0)
            y = y + FULL_TURN;
         att_yaw = y - HALF_TURN;
      end
      r.roll  = att_roll[24:0];
      r.pitch = att_pitch[24:0];
      r.yaw   = att_yaw[24:0];
      return r;
   endfunction

   function automatic logic signed [15:0] wild_raw();
      case ($urandom_range(0, 5))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sd0;
         3:       return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Drive one beat, hold it until the filter takes it, then queue the
   // expected angles (typed ones win over the predictor's).
   task automatic send_imu_beat(input imu_sample_type s, input bit typed,
                                input angles_type typed_angles);
      angles_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
      req_tuser  <= s.mode;
      do
         @(posedge clock);
      while (!req_tready);
      predicted = update_attitude(s);
      pending_angles.push_back(typed ? typed_angles : predicted);
   endtask

   // drop valid and wait until every queued result beat has come back
   task automatic await_results();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (pending_angles.size() != 0)
         @(posedge clock);
   endtask

   // write both registers back to back; call only while idle
   task automatic write_filter_config(input logic [16:0] weight,
                                      input logic [15:0] period);
      csr_wr_en <= 1'b1;
      csr_index <= REG_BLEND_WEIGHT;
      csr_wdata <= weight;
      @(posedge clock);
      csr_index <= REG_SAMPLE_PERIOD;
      csr_wdata <= {1'b0, period};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      cfg_weight = weight;
      cfg_period = period;
   endtask

   // Result side: stall in random bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Score each result beat against the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_angles.roll  = rsp_tdata[24:0];
         seen_angles.pitch = rsp_tdata[49:25];
         seen_angles.yaw   = rsp_tdata[74:50];
         if (pending_angles.size() == 0) begin
            $display("%0t: result beat with nothing expected: roll %0d pitch %0d yaw %0d",
                     $time, seen_angles.roll, seen_angles.pitch, seen_angles.yaw);
            mismatch_count++;
         end else begin
            head_angles = pending_angles.pop_front();
            if (seen_angles.roll !== head_angles.roll) begin
               $display("%0t: roll expected %0d actual %0d",
                        $time, head_angles.roll, seen_angles.roll);
               mismatch_count++;
            end
            if (seen_angles.pitch !== head_angles.pitch) begin
               $display("%0t: pitch expected %0d actual %0d",
                        $time, head_angles.pitch, seen_angles.pitch);
               mismatch_count++;
            end
            if (seen_angles.yaw !== head_angles.yaw) begin
               $display("%0t: yaw expected %0d actual %0d",
                        $time, head_angles.yaw, seen_angles.yaw);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      stim_row_type   row;
      imu_sample_type s;
      angles_type     typed_val;
      int             style;
      logic [16:0]    next_weight;
      logic [15:0]    next_period;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = REG_BLEND_WEIGHT;
      csr_wdata  = '0;

      att_roll   = 0;
      att_pitch  = 0;
      att_yaw    = 0;
      cfg_weight = 64225;
      cfg_period = 655;

      // Directed table. Typed expectations only where obvious: the first
      // all-zero sample after reset and the clear beats.
      dir_rows = '{
         // the very first beat: no tilt, no rate
         '{ROW_SAMPLE, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0},
         // level, then roll tilt at the axis extremes and in the left half plane
         '{ROW_SAMPLE, 0, 0, 16384, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 32767, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, -32768, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, -32768, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, -1, -32768, 0, 0, 0, 1'b0, 0, 0, 0},
         // pitch tilt, first with no y/z component
         '{ROW_SAMPLE, -32768, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 32767, 100, -200, 16, -16, 16, 1'b0, 0, 0, 0},
         // full-scale rates
         '{ROW_SAMPLE, 0, 0, 16384, 32767, 32767, 32767, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16384, -32768, -32768, -32768, 1'b0, 0, 0, 0},
         // clear ignores every other field
         '{ROW_CLEAR, -1, -1, -1, -1, -1, -1, 1'b1, 0, 0, 0},
         // gyro only, longest period: roll/pitch saturate, yaw wraps
         '{ROW_CONFIG, 65536, 65535, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 1000, 2000, 16000, 32767, 32767, 32767, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 1000, 2000, 16000, 32767, 32767, 32767, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 1000, 2000, 16000, -32768, -32768, -32768, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 1000, 2000, 16000, -32768, -32768, -32768, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 1000, 2000, 16000, -32768, -32768, -32768, 1'b0, 0, 0, 0},
         // weight above one must act as one
         '{ROW_CONFIG, 131071, 655, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 16384, 0, -32768, -32768, -32768, 1'b0, 0, 0, 0},
         // accelerometer only, zero period: rates add nothing
         '{ROW_CONFIG, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 32767, -32768, 32767, 32767, 32767, 32767, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0, 0, 0, 0},
         // shortest nonzero period
         '{ROW_CONFIG, 64225, 1, 0, 0, 0, 0, 1'b0, 0, 0, 0},
         '{ROW_SAMPLE, 0, 0, 16384, 1, 1, -1, 1'b0, 0, 0, 0},
         '{ROW_CLEAR, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0},
         '{ROW_CONFIG, 64225, 655, 0, 0, 0, 0, 1'b0, 0, 0, 0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int k = 0; k < DIR_ROWS; k++) begin
         row = dir_rows[k];
         if (row.kind == ROW_CONFIG) begin
            await_results();
            write_filter_config(row.f0[16:0], row.f1[15:0]);
         end else begin
            s.mode = (row.kind == ROW_CLEAR);
            s.ax   = row.f0[15:0];
            s.ay   = row.f1[15:0];
            s.az   = row.f2[15:0];
            s.gx   = row.f3[15:0];
            s.gy   = row.f4[15:0];
            s.gz   = row.f5[15:0];
            typed_val.roll  = row.er[24:0];
            typed_val.pitch = row.ep[24:0];
            typed_val.yaw   = row.ey[24:0];
            send_imu_beat(s, row.typed, typed_val);
         end
      end

      // Random phases: new settings each phase, some phases without idling,
      // and the last one always without.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               next_weight = 17'd65536;
               next_period = 16'd65535;
            end
            1: begin
               next_weight = 17'd0;
               next_period = 16'd1;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0:       next_weight = 17'($urandom_range(65537, 131071));
                  1:       next_weight = 17'd65536;
                  2:       next_weight = 17'($urandom_range(60000, 65535));
                  default: next_weight = 17'($urandom_range(0, 65536));
               endcase
               next_period = ($urandom_range(0, 3) == 0) ? 16'd65535
                                                         : 16'($urandom_range(1, 3000));
            end
         endcase
         await_results();
         idle_on = (phase != PHASE_COUNT - 1) && (phase % 3 != 2);
         write_filter_config(next_weight, next_period);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            style  = $urandom_range(0, 9);
            s.mode = (style == 0);
            if (style == 0) begin
               // clear beat with junk in every field
               s.ax = 16'($urandom);
               s.ay = 16'($urandom);
               s.az = 16'($urandom);
               s.gx = 16'($urandom);
               s.gy = 16'($urandom);
               s.gz = 16'($urandom);
            end else if (style <= 6) begin
               // plausible motion: moderate gravity vector, slow rates
               s.ax = 16'(int'($urandom_range(0, 40000)) - 20000);
               s.ay = 16'(int'($urandom_range(0, 40000)) - 20000);
               s.az = 16'(int'($urandom_range(0, 40000)) - 20000);
               s.gx = 16'(int'($urandom_range(0, 1600)) - 800);
               s.gy = 16'(int'($urandom_range(0, 1600)) - 800);
               s.gz = 16'(int'($urandom_range(0, 1600)) - 800);
            end else begin
               s.ax = wild_raw();
               s.ay = wild_raw();
               s.az = wild_raw();
               s.gx = wild_raw();
               s.gy = wild_raw();
               s.gz = wild_raw();
            end
            // now and then a zero y/z pair so atan2(0, 0) shows up
            if ($urandom_range(0, 19) == 0) begin
               s.ay = 16'sd0;
               s.az = 16'sd0;
            end
            send_imu_beat(s, 1'b0, '0);
         end
      end

      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_angles.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== complementary_attitude_filter.f =====
hw/rtl/caf_pkg.sv
hw/rtl/complementary_attitude_filter.sv
tb/complementary_attitude_filter_tb.sv
